### rtl/ope_pkg.sv
// Shared widths and family codes for the orthogonal polynomial evaluator.
// No dependencies; the channel interfaces and the top level use it.
`default_nettype none

package ope_pkg;

    // Field widths of one transfer on each channel
    localparam int CMD_W = 2;
    localparam int DEG_W = 4;
    localparam int X_W   = 24;
    localparam int VAL_W = 64;

    // Polynomial family codes carried on cmd
    localparam logic [CMD_W-1:0] FAM_LEGENDRE  = 2'd0;
    localparam logic [CMD_W-1:0] FAM_HERMITE   = 2'd1;
    localparam logic [CMD_W-1:0] FAM_CHEBYSHEV = 2'd2;

endpackage

`default_nettype wire

### rtl/ope_if.sv
// Valid/ready channel interfaces for evaluation points and results.
// Depends on ope_pkg for field widths.
`default_nettype none

interface ope_in_if;
    logic                           valid;
    logic                           ready;
    logic [ope_pkg::CMD_W-1:0]      cmd;
    logic [ope_pkg::DEG_W-1:0]      degree;
    logic signed [ope_pkg::X_W-1:0] x_value;

    modport source (output valid, cmd, degree, x_value, input ready);
    modport sink   (input valid, cmd, degree, x_value, output ready);
endinterface

interface ope_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ope_pkg::VAL_W-1:0] poly_value;
    logic signed [ope_pkg::VAL_W-1:0] first_deriv;
    logic signed [ope_pkg::VAL_W-1:0] second_deriv;
    logic                             overflow;

    modport source (output valid, poly_value, first_deriv, second_deriv, overflow,
                    input ready);
    modport sink   (input valid, poly_value, first_deriv, second_deriv, overflow,
                    output ready);
endinterface

`default_nettype wire

### rtl/orthopoly_eval_with_derivatives.sv
// Orthogonal polynomial evaluator (Legendre, Hermite, Chebyshev T) with P, P', P''.
// Depends on ope_pkg and on the channel interfaces in ope_if.sv.
//
//   channel | dir | payload                                            | handshake
//   --------+-----+----------------------------------------------------+------------
//   point   | in  | cmd[1:0], degree[3:0], x_value[23:0] (Q3.20)       | valid/ready
//   result  | out | poly_value, first_deriv, second_deriv [63:0], overflow | valid/ready
//
// One transfer is taken every cycle while the pipeline is not held.
// A seed stage is followed by one five-stage section per recurrence step
// (multiply by x, assemble, scale and subtract, two divide-by-i stages).
// Steps above the item's degree pass the state through unchanged.
// The whole pipeline holds while a result waits and result.ready is low.
// rst_n clears the valid bits only.
`default_nettype none

module orthopoly_eval_with_derivatives #(
    parameter int MAX_DEGREE = 5,
    parameter int FRAC_BITS  = 20
) (
    input  wire        clk,
    input  wire        rst_n,
    ope_in_if.sink     point,
    ope_out_if.source  result
);

    localparam int S = 32 - FRAC_BITS;
    localparam logic [56:0] RND     = 57'(1) << (FRAC_BITS - 1);
    localparam logic [63:0] ONE     = 64'(1) << FRAC_BITS;
    localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

    // Item state between recurrence steps; channel 0 value, 1 first, 2 second
    typedef struct packed {
        logic [ope_pkg::CMD_W-1:0] fam;
        logic [ope_pkg::DEG_W-1:0] n;
        logic                      xneg;
        logic [23:0]               xm;
        logic                      ovf;
        logic [2:0][63:0]          prev;
        logic [2:0][63:0]          cur;
    } st_t;

    typedef struct packed {
        logic        o;
        logic [63:0] v;
    } sres_t;

    typedef struct packed {
        logic        neg;
        logic [55:0] hi;
        logic [56:0] lo;
    } mxp_t;

    function automatic logic [63:0] mag(input logic [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    // Signed result from sign and magnitude, clamped to the 64-bit range
    function automatic sres_t from_mag(input logic neg, input logic [79:0] m);
        sres_t r;
        logic  big;
        big = |m[79:63];
        if (!neg)
        begin
            r.o = big;
            r.v = big ? SAT_MAX : m[63:0];
        end
        else
        begin
            r.o = big && (m != (80'(1) << 63));
            r.v = big ? SAT_MIN : (~m[63:0] + 64'd1);
        end
        return r;
    endfunction

    function automatic sres_t sat_add(input logic [63:0] a, input logic [63:0] b);
        sres_t       r;
        logic [63:0] s;
        s   = a + b;
        r.o = (a[63] == b[63]) && (s[63] != a[63]);
        r.v = r.o ? (a[63] ? SAT_MIN : SAT_MAX) : s;
        return r;
    endfunction

    function automatic sres_t sat_sub(input logic [63:0] a, input logic [63:0] b);
        sres_t       r;
        logic [63:0] s;
        s   = a - b;
        r.o = (a[63] != b[63]) && (s[63] != a[63]);
        r.v = r.o ? (a[63] ? SAT_MIN : SAT_MAX) : s;
        return r;
    endfunction

    function automatic sres_t mul_small(input logic [63:0] a, input logic [4:0] k);
        logic [79:0] p;
        p = 80'(mag(a)) * 80'(k);
        return from_mag(a[63], p);
    endfunction

    // Quotient and remainder nibbles of {rem, digit} / d, built at elaboration
    function automatic logic [255:0][7:0] dtab_build(input int d);
        logic [255:0][7:0] tab;
        int                r;
        int                q;
        for (int c = 0; c < 256; c++)
        begin
            r = c;
            q = 0;
            for (int k = 0; k < 16; k++)
            begin
                if (r >= d)
                begin
                    r = r - d;
                    q = q + 1;
                end
            end
            tab[c] = {4'(q), 4'(r)};
        end
        return tab;
    endfunction

    st_t  bnd     [1:MAX_DEGREE];
    logic bnd_vld [1:MAX_DEGREE];
    logic advance;

    // Hold every stage while the finished result is not taken
    assign advance     = !bnd_vld[MAX_DEGREE] || result.ready;
    assign point.ready = advance;

    // Seed stage: degree 0 and 1 values
    st_t  seed_st_next, seed_st_reg;
    logic seed_vld_reg;

    always_comb
    begin
        logic [63:0] xs;
        xs = {{40{point.x_value[23]}}, point.x_value};
        seed_st_next = '0;
        case (point.cmd)
            ope_pkg::FAM_LEGENDRE,
            ope_pkg::FAM_HERMITE,
            ope_pkg::FAM_CHEBYSHEV: seed_st_next.fam = point.cmd;
            default:                seed_st_next.fam = ope_pkg::FAM_CHEBYSHEV;
        endcase
        seed_st_next.n = (point.degree > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE) : point.degree;
        seed_st_next.xneg = point.x_value[23];
        seed_st_next.xm   = point.x_value[23] ? (~point.x_value + 24'd1) : point.x_value;
        seed_st_next.ovf  = 1'b0;
        seed_st_next.prev[0] = ONE;
        seed_st_next.prev[1] = '0;
        seed_st_next.prev[2] = '0;
        if (seed_st_next.fam == ope_pkg::FAM_HERMITE)
        begin
            seed_st_next.cur[0] = xs << 1;
            seed_st_next.cur[1] = ONE << 1;
        end
        else
        begin
            seed_st_next.cur[0] = xs;
            seed_st_next.cur[1] = ONE;
        end
        seed_st_next.cur[2] = '0;
        if (seed_st_next.n == '0)
        begin
            seed_st_next.cur[0] = ONE;
            seed_st_next.cur[1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_vld_reg <= 1'b0;
        else if (advance)
            seed_vld_reg <= point.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            seed_st_reg <= seed_st_next;
    end

    assign bnd[1]     = seed_st_reg;
    assign bnd_vld[1] = seed_vld_reg;

    // One pipeline section per recurrence step i
    for (genvar g = 2; g <= MAX_DEGREE; g++)
    begin : g_step
        localparam int                HALF   = g / 2;
        localparam logic [4:0]        KA_LEG = 5'(2 * g - 1);
        localparam logic [4:0]        KB_LEG = 5'(g - 1);
        localparam logic [4:0]        KB_HER = 5'(2 * (g - 1));
        localparam logic [255:0][7:0] DTAB   = dtab_build(g);

        st_t              m_st_reg, t_st_reg, c_st_reg, d1_st_reg, d2_st_reg, d2_st_next;
        logic             m_vld_reg, t_vld_reg, c_vld_reg, d1_vld_reg, d2_vld_reg;
        mxp_t [2:0]       m_mx_next, m_mx_reg;
        logic [2:0][63:0] t_t_next, t_t_reg;
        logic             t_o_next, t_o_reg;
        logic [2:0][63:0] c_dif_next, c_dif_reg, d1_dif_reg;
        logic             c_o_next, c_o_reg, d1_o_reg;
        logic [2:0][31:0] d1_qh_next, d1_qh_reg, d1_lo_next, d1_lo_reg;
        logic [2:0][3:0]  d1_rem_next, d1_rem_reg;

        // Split each product with x into two 32 x 24 partial products
        always_comb
        begin
            logic [63:0] am;
            for (int ch = 0; ch < 3; ch++)
            begin
                am = mag(bnd[g-1].cur[ch]);
                m_mx_next[ch].neg = bnd[g-1].cur[ch][63] ^ bnd[g-1].xneg;
                m_mx_next[ch].hi  = 56'(am[63:32]) * 56'(bnd[g-1].xm);
                m_mx_next[ch].lo  = 57'(am[31:0]) * 57'(bnd[g-1].xm) + RND;
            end
        end

        // Assemble the rounded products and form the T terms
        always_comb
        begin
            sres_t       mx [3];
            sres_t       s1;
            sres_t       d2x;
            sres_t       s2;
            logic [79:0] w;
            for (int ch = 0; ch < 3; ch++)
            begin
                w = (80'(m_mx_reg[ch].hi) << S) + (80'(m_mx_reg[ch].lo) >> FRAC_BITS);
                mx[ch] = from_mag(m_mx_reg[ch].neg, w);
            end
            s1  = sat_add(m_st_reg.cur[0], mx[1].v);
            d2x = mul_small(m_st_reg.cur[1], 5'd2);
            s2  = sat_add(d2x.v, mx[2].v);
            t_t_next[0] = mx[0].v;
            t_t_next[1] = s1.v;
            t_t_next[2] = s2.v;
            t_o_next = mx[0].o | mx[1].o | mx[2].o | s1.o | d2x.o | s2.o;
        end

        // Scale by the family coefficients and subtract
        always_comb
        begin
            logic [4:0] ka;
            logic [4:0] kb;
            sres_t      a;
            sres_t      b;
            sres_t      s;
            case (t_st_reg.fam)
                ope_pkg::FAM_LEGENDRE:
                begin
                    ka = KA_LEG;
                    kb = KB_LEG;
                end
                ope_pkg::FAM_HERMITE:
                begin
                    ka = 5'd2;
                    kb = KB_HER;
                end
                default:
                begin
                    ka = 5'd2;
                    kb = 5'd1;
                end
            endcase
            c_o_next = t_o_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                a = mul_small(t_t_reg[ch], ka);
                b = mul_small(t_st_reg.prev[ch], kb);
                s = sat_sub(a.v, b.v);
                c_dif_next[ch] = s.v;
                c_o_next = c_o_next | a.o | b.o | s.o;
            end
        end

        // Divide by i, upper eight digits
        always_comb
        begin
            logic [63:0] m;
            logic [3:0]  rem;
            logic [7:0]  e;
            for (int ch = 0; ch < 3; ch++)
            begin
                m   = mag(c_dif_reg[ch]) + 64'(HALF);
                rem = '0;
                d1_qh_next[ch] = '0;
                for (int j = 15; j >= 8; j--)
                begin
                    e   = DTAB[{rem, m[4*j +: 4]}];
                    d1_qh_next[ch][4*(j-8) +: 4] = e[7:4];
                    rem = e[3:0];
                end
                d1_rem_next[ch] = rem;
                d1_lo_next[ch]  = m[31:0];
            end
        end

        // Divide by i, lower eight digits, then commit the step
        always_comb
        begin
            logic [31:0] ql;
            logic [3:0]  rem;
            logic [7:0]  e;
            sres_t       r;
            logic        leg;
            logic        o;
            logic [2:0][63:0] nv;
            leg = (d1_st_reg.fam == ope_pkg::FAM_LEGENDRE);
            o   = d1_o_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                rem = d1_rem_reg[ch];
                ql  = '0;
                for (int j = 7; j >= 0; j--)
                begin
                    e   = DTAB[{rem, d1_lo_reg[ch][4*j +: 4]}];
                    ql[4*j +: 4] = e[7:4];
                    rem = e[3:0];
                end
                r = from_mag(d1_dif_reg[ch][63], 80'({d1_qh_reg[ch], ql}));
                nv[ch] = leg ? r.v : d1_dif_reg[ch];
                o = o | (leg & r.o);
            end
            d2_st_next = d1_st_reg;
            if (d1_st_reg.n >= 4'(g))
            begin
                d2_st_next.prev = d1_st_reg.cur;
                d2_st_next.cur  = nv;
                d2_st_next.ovf  = d1_st_reg.ovf | o;
            end
        end

        // Advance valid bits
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                m_vld_reg  <= 1'b0;
                t_vld_reg  <= 1'b0;
                c_vld_reg  <= 1'b0;
                d1_vld_reg <= 1'b0;
                d2_vld_reg <= 1'b0;
            end
            else if (advance)
            begin
                m_vld_reg  <= bnd_vld[g-1];
                t_vld_reg  <= m_vld_reg;
                c_vld_reg  <= t_vld_reg;
                d1_vld_reg <= c_vld_reg;
                d2_vld_reg <= d1_vld_reg;
            end
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                m_st_reg    <= bnd[g-1];
                m_mx_reg    <= m_mx_next;
                t_st_reg    <= m_st_reg;
                t_t_reg     <= t_t_next;
                t_o_reg     <= t_o_next;
                c_st_reg    <= t_st_reg;
                c_dif_reg   <= c_dif_next;
                c_o_reg     <= c_o_next;
                d1_st_reg   <= c_st_reg;
                d1_dif_reg  <= c_dif_reg;
                d1_o_reg    <= c_o_reg;
                d1_qh_reg   <= d1_qh_next;
                d1_lo_reg   <= d1_lo_next;
                d1_rem_reg  <= d1_rem_next;
                d2_st_reg   <= d2_st_next;
            end
        end

        assign bnd[g]     = d2_st_reg;
        assign bnd_vld[g] = d2_vld_reg;
    end

    // Drive the result channel from the last stage
    assign result.valid        = bnd_vld[MAX_DEGREE];
    assign result.poly_value   = bnd[MAX_DEGREE].cur[0];
    assign result.first_deriv  = bnd[MAX_DEGREE].cur[1];
    assign result.second_deriv = bnd[MAX_DEGREE].cur[2];
    assign result.overflow     = bnd[MAX_DEGREE].ovf;

endmodule

`default_nettype wire

### verif/orthopoly_eval_with_derivatives_tb.sv
// Testbench for the orthogonal polynomial evaluator: predicts P, P', P'' per point.
// Depends on ope_pkg, ope_if.sv and the orthopoly_eval_with_derivatives RTL.
`default_nettype none

module orthopoly_eval_with_derivatives_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXDEG = 5;
    localparam int FRAC   = 20;
    localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SMIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [63:0] val;
        logic signed [63:0] d1;
        logic signed [63:0] d2;
        logic               ovf;
    } poly_res_t;

    logic clk;
    logic rst_n;
    int   n_bad;

    ope_in_if  point();
    ope_out_if result();

    orthopoly_eval_with_derivatives dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point.sink),
        .result (result.source)
    );

    // Print one line per mismatch and count it
    task automatic report(input string what, input logic signed [63:0] got,
                          input logic signed [63:0] want);
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
        n_bad++;
    endtask

    // Clamp a wide value to the signed 64-bit range, flagging saturation
    function automatic longint clamp(input logic signed [129:0] v, inout bit f);
        if (v > 130'(SMAX)) begin
            f = 1;
            return SMAX;
        end
        if (v < 130'(SMIN)) begin
            f = 1;
            return SMIN;
        end
        return longint'(v);
    endfunction

    function automatic logic [129:0] mag(input logic signed [129:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Product with x, rounded half away from zero
    function automatic longint times_x(input longint a, input longint x, inout bit f);
        logic signed [129:0] p;
        logic [129:0] m;
        p = 130'(a) * 130'(x);
        m = (mag(p) + (130'd1 << (FRAC - 1))) >> FRAC;
        return clamp(p < 0 ? -$signed(m) : $signed(m), f);
    endfunction

    // (ka*t - kb*u)/d with per-step saturation and rounded division
    function automatic longint combine3(input longint t, input longint u, input int ka,
                                        input int kb, input int d, inout bit f);
        longint s;
        logic [129:0] m;
        s = clamp(clamp(130'(t) * ka, f) - 130'(clamp(130'(u) * kb, f)), f);
        if (d <= 1)
            return s;
        m = (mag(130'(s)) + (d >> 1)) / d;
        return clamp(s < 0 ? -$signed(m) : $signed(m), f);
    endfunction

    function automatic poly_res_t eval_poly(input logic [1:0] fam_in, input logic [3:0] deg,
                                            input logic signed [23:0] xv);
        logic [1:0] fam;
        int n, ka, kb, dv;
        longint x, one, p0, p1, dp0, dp1, dd0, dd1, nv, nd, ndd;
        bit f;
        poly_res_t r;
        fam = (fam_in == 2'd3) ? ope_pkg::FAM_CHEBYSHEV : fam_in;
        n = deg > MAXDEG ? MAXDEG : deg;
        x = xv;
        one = 64'sd1 << FRAC;
        f = 0;
        p0 = one; dp0 = 0; dd0 = 0; dd1 = 0;
        p1 = (fam == ope_pkg::FAM_HERMITE) ? 2 * x : x;
        dp1 = (fam == ope_pkg::FAM_HERMITE) ? 2 * one : one;
        if (n == 0) begin
            p1 = one;
            dp1 = 0;
        end
        for (int i = 2; i <= n; i++) begin
            if (fam == ope_pkg::FAM_LEGENDRE) begin
                ka = 2 * i - 1; kb = i - 1; dv = i;
            end else if (fam == ope_pkg::FAM_HERMITE) begin
                ka = 2; kb = 2 * (i - 1); dv = 1;
            end else begin
                ka = 2; kb = 1; dv = 1;
            end
            nv  = combine3(times_x(p1, x, f), p0, ka, kb, dv, f);
            nd  = combine3(clamp(130'(p1) + 130'(times_x(dp1, x, f)), f), dp0, ka, kb, dv, f);
            ndd = combine3(clamp(130'(clamp(130'(dp1) * 2, f)) + 130'(times_x(dd1, x, f)), f),
                           dd0, ka, kb, dv, f);
            p0 = p1; p1 = nv; dp0 = dp1; dp1 = nd; dd0 = dd1; dd1 = ndd;
        end
        r.val = p1; r.d1 = dp1; r.d2 = dd1; r.ovf = f;
        return r;
    endfunction

    // Holds expected results in order of accepted points
    class poly_scoreboard;
        poly_res_t pending[$];

        function void note_point(logic [1:0] c, logic [3:0] d, logic signed [23:0] x);
            pending = {pending, eval_poly(c, d, x)};
        endfunction

        task check_result(poly_res_t got);
            poly_res_t want;
            if (pending.size() == 0) begin
                report("unexpected result", got.val, 0);
                return;
            end
            want = pending.pop_front();
            if (got.val !== want.val) report("poly_value", got.val, want.val);
            if (got.d1 !== want.d1) report("first_deriv", got.d1, want.d1);
            if (got.d2 !== want.d2) report("second_deriv", got.d2, want.d2);
            if (got.ovf !== want.ovf) report("overflow", got.ovf, want.ovf);
        endtask
    endclass

    poly_scoreboard sb;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Offer one point and hold it until the transfer; drop valid only for a gap
    task automatic send_point(input logic [1:0] c, input logic [3:0] d,
                              input logic signed [23:0] x);
        int g;
        g = gap_len();
        if (g > 0) begin
            point.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        point.valid   <= 1'b1;
        point.cmd     <= c;
        point.degree  <= d;
        point.x_value <= x;
        do @(posedge clk); while (!point.ready);
        sb.note_point(c, d, x);
    endtask

    // Random back-pressure on the result side; check each transfer
    initial begin
        poly_res_t got;
        int g;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (result.valid && result.ready) begin
                got.val = result.poly_value; got.d1 = result.first_deriv;
                got.d2 = result.second_deriv; got.ovf = result.overflow;
                sb.check_result(got);
            end
            if (g > 0) begin
                g--;
                result.ready <= 1'b0;
            end else begin
                g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                result.ready <= (g == 0);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("orthopoly_eval_with_derivatives: mismatch");
        $finish;
    end

    initial begin
        logic [1:0] c;
        logic signed [23:0] x;
        int wait_n;
        sb = new();
        n_bad = 0;
        rst_n = 1'b0;
        point.valid = 1'b0;
        point.cmd = '0;
        point.degree = '0;
        point.x_value = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each family code, degrees 0, 1, 3, 4, 5 and 15, extreme and small points
        for (int f = 0; f < 4; f++) begin
            send_point(f[1:0], 4'd0, 24'sh7FFFFF);
            send_point(f[1:0], 4'd1, 24'sh800000);
            send_point(f[1:0], 4'd5, 24'sh7FFFFF);
            send_point(f[1:0], 4'd15, 24'sh800000);
            send_point(f[1:0], 4'd3, 24'sh100000);
            send_point(f[1:0], 4'd4, -24'sh000001);
        end

        // Random: mostly valid families, all degrees and x bits
        for (int k = 0; k < 1200; k++) begin
            c = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            x = $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 24'hFFFFFF))
                                          : 24'($signed($urandom_range(0, 8'hFF) << 13)) >>>
                                            $urandom_range(0, 12);
            send_point(c, 4'($urandom_range(0, 15)), x);
        end
        point.valid <= 1'b0;

        wait_n = 0;
        while (sb.pending.size() != 0 && wait_n < 200_000) begin
            @(posedge clk);
            wait_n++;
        end
        repeat (40) @(posedge clk);
        if (n_bad == 0 && sb.pending.size() == 0)
            $display("orthopoly_eval_with_derivatives: match");
        else
            $display("orthopoly_eval_with_derivatives: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
